>>> sv/prf_pkg.sv
// ============================================================================
// Publisher replay filter package
// Shared types and constants for the replay filter cell chain and its top
// level.
// ============================================================================
package prf_pkg;

   localparam int unsigned FIELD_WIDTH = 32;
   localparam int unsigned LIMIT_WIDTH = 5;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 5'd16;
   localparam logic [FIELD_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      VERDICT_ACCEPTED    = 3'd0,
      VERDICT_DUPLICATE   = 3'd1,
      VERDICT_STALE_INC   = 3'd2,
      VERDICT_STALE_BOOT  = 3'd3,
      VERDICT_STALE_EPOCH = 3'd4,
      VERDICT_MALFORMED   = 3'd5,
      VERDICT_FULL        = 3'd6
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   // One transaction as the cells see it while the lookup walks the chain.
   typedef struct packed {
      logic                   well_formed;
      logic [FIELD_WIDTH-1:0] publisher_id;
      logic [FIELD_WIDTH-1:0] incarnation;
      logic [FIELD_WIDTH-1:0] boot_id;
      logic [FIELD_WIDTH-1:0] epoch;
      logic [FIELD_WIDTH-1:0] sequence_number;
   } item_type;

   // Lookup token handed from one cell to the next.
   typedef struct packed {
      logic                   tok;
      logic                   hit;
      verdict_type            verdict;
      logic [FIELD_WIDTH-1:0] acc;
      logic [FIELD_WIDTH-1:0] dup;
      logic                   free_seen;
   } carry_type;

   function automatic logic [FIELD_WIDTH-1:0] sat_inc(input logic [FIELD_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

>>> sv/prf_cell.sv
// ============================================================================
// Publisher replay filter cell
// Holds one table entry. When the lookup token passes, a matching entry
// classifies the transaction and updates itself; the first free entry
// in the chain marks itself as a candidate for insertion.
// ============================================================================
module prf_cell #(
   parameter int unsigned IDX_WIDTH  = 4,
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  prf_pkg::item_type        item,
   input  prf_pkg::carry_type       carry_in,
   input  logic [IDX_WIDTH-1:0]     free_idx_in,
   input  logic                     ins_en,
   input  logic [IDX_WIDTH-1:0]     ins_idx,
   output prf_pkg::carry_type       carry_out,
   output logic [IDX_WIDTH-1:0]     free_idx_out
);

   localparam logic [IDX_WIDTH-1:0] MY_INDEX = IDX_WIDTH'(CELL_INDEX);

   logic                                used_ff;
   logic [prf_pkg::FIELD_WIDTH-1:0]     pub_ff;
   logic [prf_pkg::FIELD_WIDTH-1:0]     inc_ff;
   logic [prf_pkg::FIELD_WIDTH-1:0]     boot_ff;
   logic [prf_pkg::FIELD_WIDTH-1:0]     epoch_ff;
   logic [prf_pkg::FIELD_WIDTH-1:0]     seq_ff;
   logic [prf_pkg::FIELD_WIDTH-1:0]     acc_ff;
   logic [prf_pkg::FIELD_WIDTH-1:0]     dup_ff;
   prf_pkg::carry_type                  carry_ff;
   logic [IDX_WIDTH-1:0]                free_idx_ff;

   logic                                match;
   logic                                upd_seq;
   logic                                upd_inc;
   logic                                upd_dup;
   prf_pkg::verdict_type                verdict;
   logic [prf_pkg::FIELD_WIDTH-1:0]     acc_in;
   logic [prf_pkg::FIELD_WIDTH-1:0]     dup_in;
   prf_pkg::carry_type                  carry_in_next;
   logic [IDX_WIDTH-1:0]                free_idx_in_next;
   logic                                ins_hit;

   assign match   = carry_in.tok && used_ff && (pub_ff == item.publisher_id);
   assign ins_hit = ins_en && (ins_idx == MY_INDEX);

   always_comb begin
      upd_seq = 1'b0;
      upd_inc = 1'b0;
      upd_dup = 1'b0;
      if (!item.well_formed) begin
         verdict = prf_pkg::VERDICT_MALFORMED;
      end else if (item.incarnation < inc_ff) begin
         verdict = prf_pkg::VERDICT_STALE_INC;
      end else if (item.incarnation == inc_ff) begin
         if (item.boot_id != boot_ff) begin
            verdict = prf_pkg::VERDICT_STALE_BOOT;
         end else if (item.epoch < epoch_ff) begin
            verdict = prf_pkg::VERDICT_STALE_EPOCH;
         end else if (item.sequence_number <= seq_ff) begin
            verdict = prf_pkg::VERDICT_DUPLICATE;
            upd_dup = 1'b1;
         end else begin
            verdict = prf_pkg::VERDICT_ACCEPTED;
            upd_seq = 1'b1;
         end
      end else begin
         // A newer incarnation restarts the sequence space.
         verdict = prf_pkg::VERDICT_ACCEPTED;
         upd_seq = 1'b1;
         upd_inc = 1'b1;
      end
      acc_in = upd_seq ? prf_pkg::sat_inc(acc_ff) : acc_ff;
      dup_in = upd_dup ? prf_pkg::sat_inc(dup_ff) : dup_ff;
   end

   always_comb begin
      carry_in_next    = carry_in;
      free_idx_in_next = free_idx_in;
      if (match) begin
         carry_in_next.hit     = 1'b1;
         carry_in_next.verdict = verdict;
         carry_in_next.acc     = acc_in;
         carry_in_next.dup     = dup_in;
      end
      if (carry_in.tok && !carry_in.free_seen && !used_ff) begin
         carry_in_next.free_seen = 1'b1;
         free_idx_in_next        = MY_INDEX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in_next;
      end
      free_idx_ff <= free_idx_in_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (ins_hit) begin
         used_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ins_hit) begin
         pub_ff   <= item.publisher_id;
         inc_ff   <= item.incarnation;
         boot_ff  <= item.boot_id;
         epoch_ff <= item.epoch;
         seq_ff   <= item.sequence_number;
         acc_ff   <= prf_pkg::FIELD_WIDTH'(1);
         dup_ff   <= '0;
      end else if (match) begin
         if (upd_inc) begin
            inc_ff  <= item.incarnation;
            boot_ff <= item.boot_id;
         end
         if (upd_seq) begin
            epoch_ff <= item.epoch;
            seq_ff   <= item.sequence_number;
         end
         acc_ff <= acc_in;
         dup_ff <= dup_in;
      end
   end

   assign carry_out    = carry_ff;
   assign free_idx_out = free_idx_ff;

endmodule

>>> sv/publisher_replay_filter_core.sv
// ============================================================================
// Publisher replay filter
// Per-publisher anti-replay table built as a chain of entry cells.
// ============================================================================
// A transaction on the req_ channel carries one message header. The block
// looks the publisher up in its table and returns one verdict on the rsp_
// channel, together with whether the publisher holds an entry afterwards
// and that entry's accepted and duplicate counts.
// The lookup token walks the cell chain one cell per cycle, passing the start
// register and each cell's register; the chain tail is then captured and the
// response loaded into the output register. No new request is taken until
// the previous lookup has loaded its response. A new publisher is written
// into the lowest free cell in the cycle the response is loaded.
// The response sits in an output register, so the next request is taken
// while the response still waits for rsp_ready; if the receiver stalls,
// the following lookup completes and then holds until the register frees.
// csr_write_enable writes publisher_limit at once; write it only while idle.
// Reset empties the table, clears the occupancy count, sets publisher_limit
// to 16 and drops any response in flight.
// ============================================================================
module publisher_replay_filter_core #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_well_formed,
   input  logic [prf_pkg::FIELD_WIDTH-1:0]     req_publisher_id,
   input  logic [prf_pkg::FIELD_WIDTH-1:0]     req_incarnation,
   input  logic [prf_pkg::FIELD_WIDTH-1:0]     req_boot_id,
   input  logic [prf_pkg::FIELD_WIDTH-1:0]     req_epoch,
   input  logic [prf_pkg::FIELD_WIDTH-1:0]     req_sequence_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_verdict,
   output logic                                rsp_entry_present,
   output logic [prf_pkg::FIELD_WIDTH-1:0]     rsp_accepted_total,
   output logic [prf_pkg::FIELD_WIDTH-1:0]     rsp_duplicate_total,
   input  logic                                csr_write_enable,
   input  logic [prf_pkg::LIMIT_WIDTH-1:0]     csr_write_data
);

   localparam int unsigned IDX_WIDTH = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned OCC_WIDTH = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned CMP_WIDTH =
      (OCC_WIDTH > prf_pkg::LIMIT_WIDTH) ? OCC_WIDTH : prf_pkg::LIMIT_WIDTH;
   localparam logic [CMP_WIDTH-1:0] DEPTH_CMP = CMP_WIDTH'(TABLE_DEPTH);

   prf_pkg::state_type                  state_ff;
   prf_pkg::state_type                  state_in;
   prf_pkg::item_type                   item_ff;
   logic                                start_ff;
   logic [prf_pkg::LIMIT_WIDTH-1:0]     limit_ff;
   logic [OCC_WIDTH-1:0]                occ_ff;
   prf_pkg::carry_type                  tail_ff;
   logic [IDX_WIDTH-1:0]                tail_free_idx_ff;

   logic                                rsp_valid_ff;
   prf_pkg::verdict_type                rsp_verdict_ff;
   logic                                rsp_present_ff;
   logic [prf_pkg::FIELD_WIDTH-1:0]     rsp_acc_ff;
   logic [prf_pkg::FIELD_WIDTH-1:0]     rsp_dup_ff;

   prf_pkg::carry_type                  carry_chain [0:TABLE_DEPTH];
   logic [IDX_WIDTH-1:0]                free_chain  [0:TABLE_DEPTH];

   logic                                req_fire;
   logic                                capture_tail;
   logic                                finish_fire;
   logic                                slot_free;
   logic [CMP_WIDTH-1:0]                limit_ext;
   logic [CMP_WIDTH-1:0]                limit_eff;
   logic                                table_full;
   logic                                do_insert;
   prf_pkg::verdict_type                final_verdict;
   logic                                final_present;
   logic [prf_pkg::FIELD_WIDTH-1:0]     final_acc;
   logic [prf_pkg::FIELD_WIDTH-1:0]     final_dup;

   // --------------------------------------------------------------------
   // Control
   // --------------------------------------------------------------------
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = prf_pkg::ST_WALK;
            end
         end
         prf_pkg::ST_WALK: begin
            if (carry_chain[TABLE_DEPTH].tok) begin
               state_in = prf_pkg::ST_FINISH;
            end
         end
         prf_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = prf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      capture_tail = 1'b0;
      finish_fire  = 1'b0;
      unique case (state_ff)
         prf_pkg::ST_IDLE:   req_ready    = 1'b1;
         prf_pkg::ST_WALK:   capture_tail = carry_chain[TABLE_DEPTH].tok;
         prf_pkg::ST_FINISH: finish_fire  = slot_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prf_pkg::ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.well_formed     <= req_well_formed;
         item_ff.publisher_id    <= req_publisher_id;
         item_ff.incarnation     <= req_incarnation;
         item_ff.boot_id         <= req_boot_id;
         item_ff.epoch           <= req_epoch;
         item_ff.sequence_number <= req_sequence_number;
      end
      if (capture_tail) begin
         tail_ff          <= carry_chain[TABLE_DEPTH];
         tail_free_idx_ff <= free_chain[TABLE_DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= prf_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // --------------------------------------------------------------------
   // Cell chain
   // --------------------------------------------------------------------
   always_comb begin
      carry_chain[0]           = '0;
      carry_chain[0].tok       = start_ff;
      carry_chain[0].verdict   = prf_pkg::VERDICT_MALFORMED;
      free_chain[0]            = '0;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      prf_cell #(
         .IDX_WIDTH  (IDX_WIDTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .item         (item_ff),
         .carry_in     (carry_chain[i]),
         .free_idx_in  (free_chain[i]),
         .ins_en       (do_insert),
         .ins_idx      (tail_free_idx_ff),
         .carry_out    (carry_chain[i+1]),
         .free_idx_out (free_chain[i+1])
      );
   end

   // --------------------------------------------------------------------
   // Final verdict and insertion
   // --------------------------------------------------------------------
   assign limit_ext  = CMP_WIDTH'(limit_ff);
   assign limit_eff  = (limit_ext > DEPTH_CMP) ? DEPTH_CMP : limit_ext;
   assign table_full = (CMP_WIDTH'(occ_ff) >= limit_eff) || !tail_ff.free_seen;

   always_comb begin
      do_insert     = 1'b0;
      final_verdict = prf_pkg::VERDICT_MALFORMED;
      final_present = 1'b0;
      final_acc     = '0;
      final_dup     = '0;
      if (tail_ff.hit) begin
         final_verdict = tail_ff.verdict;
         final_present = 1'b1;
         final_acc     = tail_ff.acc;
         final_dup     = tail_ff.dup;
      end else if (!item_ff.well_formed) begin
         final_verdict = prf_pkg::VERDICT_MALFORMED;
      end else if (table_full) begin
         final_verdict = prf_pkg::VERDICT_FULL;
      end else begin
         final_verdict = prf_pkg::VERDICT_ACCEPTED;
         final_present = 1'b1;
         final_acc     = prf_pkg::FIELD_WIDTH'(1);
         do_insert     = finish_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (do_insert) begin
         occ_ff <= occ_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_fire) begin
         rsp_verdict_ff <= final_verdict;
         rsp_present_ff <= final_present;
         rsp_acc_ff     <= final_acc;
         rsp_dup_ff     <= final_dup;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_entry_present   = rsp_present_ff;
   assign rsp_accepted_total  = rsp_acc_ff;
   assign rsp_duplicate_total = rsp_dup_ff;

endmodule
